// ----- hw/rtl/rect_blit_fill_engine_top_assert.svh -----
// Assertion macros for the rectangle blit and fill engine.
`ifndef RECT_BLIT_FILL_ENGINE_TOP_ASSERT_SVH
`define RECT_BLIT_FILL_ENGINE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define RBF_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RBF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RBF_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define RBF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/rbf_pkg.sv -----
// ----------------------------------------------------------------------------
// rbf_pkg
// Shared types and codes of the rectangle blit and fill engine.
// ----------------------------------------------------------------------------
package rbf_pkg;

  localparam logic [2:0] KIND_WR_SRC = 3'd0;
  localparam logic [2:0] KIND_WR_DST = 3'd1;
  localparam logic [2:0] KIND_RD_DST = 3'd2;
  localparam logic [2:0] KIND_COPY   = 3'd3;
  localparam logic [2:0] KIND_FILL   = 3'd4;

  localparam logic [2:0] REG_SRC_W  = 3'd0;
  localparam logic [2:0] REG_SRC_H  = 3'd1;
  localparam logic [2:0] REG_DST_W  = 3'd2;
  localparam logic [2:0] REG_DST_H  = 3'd3;
  localparam logic [2:0] REG_CLIP_X = 3'd4;
  localparam logic [2:0] REG_CLIP_Y = 3'd5;
  localparam logic [2:0] REG_CLIP_W = 3'd6;
  localparam logic [2:0] REG_CLIP_H = 3'd7;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture item and run clipping
    logic pix_go;    // perform the single pixel access
    logic rect_go;   // start rectangle walk
    logic step;      // one pixel of a rectangle
    logic rd_done;   // capture read data
    logic emit;      // move the finished result into the output register
  } rbf_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_rect;   // item is a nonempty copy or fill
    logic last;      // current pixel is the last of the walk
  } rbf_stat_t;

endpackage

// ----- hw/rtl/rbf_ctrl.sv -----
// ----------------------------------------------------------------------------
// rbf_ctrl
// Sequencer: takes an item, lets the datapath clip, walks rectangles, delivers.
// ----------------------------------------------------------------------------
module rbf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  rbf_pkg::rbf_stat_t stat,
  output rbf_pkg::rbf_cmd_t  cmd
);
  import rbf_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CLIP = 3'd1;
  localparam logic [2:0] ST_PIX  = 3'd2;
  localparam logic [2:0] ST_RDW  = 3'd3;
  localparam logic [2:0] ST_WALK = 3'd4;
  localparam logic [2:0] ST_WDR  = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       ovld_r, ovld_nxt;
  logic       done;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = ovld_r;

  // Decode commands and next state
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    done      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CLIP;
        end
      end
      ST_CLIP: begin
        if (stat.is_rect) begin
          cmd.rect_go = 1'b1;
          state_nxt   = ST_WALK;
        end else begin
          cmd.pix_go = 1'b1;
          state_nxt  = ST_PIX;
        end
      end
      ST_PIX: begin
        state_nxt = ST_RDW;
      end
      ST_RDW: begin
        cmd.rd_done = 1'b1;
        state_nxt   = ST_OUT;
      end
      ST_WALK: begin
        cmd.step = 1'b1;
        if (stat.last) state_nxt = ST_WDR;
      end
      ST_WDR: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free or frees in this cycle
        if (!ovld_r || out_tready) begin
          cmd.emit  = 1'b1;
          done      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output valid: set on finish, drop on transfer
  always_comb begin
    ovld_nxt = ovld_r;
    if (out_tvalid && out_tready) ovld_nxt = 1'b0;
    if (done) ovld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  `include "rect_blit_fill_engine_top_assert.svh"
  `RBF_ASSERT_NEXT(a_load_clip, clk, rst_n, cmd.load, state_r == ST_CLIP, "load not followed by clip")
  `RBF_ASSERT_IMPL(a_no_take_busy, clk, rst_n, ((state_r != ST_IDLE) |-> !in_tready), "ready while busy")
  `RBF_ASSERT_NEXT(a_done_valid, clk, rst_n, done, out_tvalid, "finished result not shown")
endmodule

// ----- hw/rtl/rbf_dp.sv -----
// ----------------------------------------------------------------------------
// rbf_dp
// Datapath: registers, clipping, rectangle address walk and both pixel stores.
// ----------------------------------------------------------------------------
module rbf_dp #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic [2:0]         cfg_index,
  input  logic [9:0]         cfg_data,
  input  logic [2:0]         kind,
  input  logic signed [10:0] pos_x,
  input  logic signed [10:0] pos_y,
  input  logic [9:0]         rect_w,
  input  logic [9:0]         rect_h,
  input  logic signed [10:0] src_x,
  input  logic signed [10:0] src_y,
  input  logic [9:0]         src_w,
  input  logic [9:0]         src_h,
  input  logic               has_src_rect,
  input  logic               has_dst_rect,
  input  logic [7:0]         pixel,
  input  rbf_pkg::rbf_cmd_t  cmd,
  output rbf_pkg::rbf_stat_t stat,
  output logic [7:0]         read_pixel,
  output logic               drawn,
  output logic [8:0]         out_x,
  output logic [7:0]         out_y,
  output logic [9:0]         out_w,
  output logic [8:0]         out_h
);
  import rbf_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(MAX_WIDTH) + 1;
  localparam int YW    = $clog2(MAX_HEIGHT) + 1;
  // signed working width: covers input sums and surface bounds
  localparam int SW    = ((XW > YW) ? XW : YW) > 12 ? (((XW > YW) ? XW : YW) + 2) : 14;

  typedef logic signed [SW-1:0] sv_t;

  // Configuration registers
  logic [9:0] src_width_r, dst_width_r, clip_w_r;
  logic [8:0] src_height_r, dst_height_r, clip_x_r, clip_h_r;
  logic [7:0] clip_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= 10'd320;
      src_height_r <= 9'd200;
      dst_width_r  <= 10'd320;
      dst_height_r <= 9'd200;
      clip_x_r     <= '0;
      clip_y_r     <= '0;
      clip_w_r     <= '0;
      clip_h_r     <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SRC_W:  src_width_r  <= cfg_data;
        REG_SRC_H:  src_height_r <= cfg_data[8:0];
        REG_DST_W:  dst_width_r  <= cfg_data;
        REG_DST_H:  dst_height_r <= cfg_data[8:0];
        REG_CLIP_X: clip_x_r     <= cfg_data[8:0];
        REG_CLIP_Y: clip_y_r     <= cfg_data[7:0];
        REG_CLIP_W: clip_w_r     <= cfg_data;
        REG_CLIP_H: clip_h_r     <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Effective surface sizes: zero acts as one, saturate at the maximum
  function automatic sv_t eff(input logic [9:0] v, input sv_t mx);
    sv_t e;
    e = sv_t'(v);
    if (v == '0) return sv_t'(1);
    if (e > mx) return mx;
    return e;
  endfunction

  sv_t spw, sph, dpw, dph;
  assign spw = eff(src_width_r, sv_t'(MAX_WIDTH));
  assign sph = eff({1'b0, src_height_r}, sv_t'(MAX_HEIGHT));
  assign dpw = eff(dst_width_r, sv_t'(MAX_WIDTH));
  assign dph = eff({1'b0, dst_height_r}, sv_t'(MAX_HEIGHT));

  // Captured item
  logic [2:0] kind_r;
  sv_t        px_r, py_r, sx_r, sy_r;
  sv_t        rw_r, rh_r, sw_r, sh_r;
  logic       hs_r, hd_r;
  logic [7:0] color_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= kind;
      px_r    <= sv_t'(pos_x);
      py_r    <= sv_t'(pos_y);
      sx_r    <= sv_t'(src_x);
      sy_r    <= sv_t'(src_y);
      rw_r    <= sv_t'(rect_w);
      rh_r    <= sv_t'(rect_h);
      sw_r    <= sv_t'(src_w);
      sh_r    <= sv_t'(src_h);
      hs_r    <= has_src_rect;
      hd_r    <= has_dst_rect;
      color_r <= pixel;
    end
  end

  // Clipping of the captured item (combinational compare and select)
  function automatic sv_t smax(input sv_t a, input sv_t b);
    return (a > b) ? a : b;
  endfunction
  function automatic sv_t smin(input sv_t a, input sv_t b);
    return (a < b) ? a : b;
  endfunction

  sv_t  s_l, s_t, s_r, s_b;
  sv_t  c_l, c_t, c_r, c_b;
  sv_t  d_l, d_t, d_r, d_b, d_wr, d_hb;
  sv_t  cw, ch;
  logic s_ok, c_ok, d_ok, rect_ok;

  always_comb begin
    // source box
    if (hs_r) begin
      s_l = smax(sx_r, '0);
      s_t = smax(sy_r, '0);
      s_r = smin(sx_r + sw_r, spw);
      s_b = smin(sy_r + sh_r, sph);
    end else begin
      s_l = '0;
      s_t = '0;
      s_r = spw;
      s_b = sph;
    end
    s_ok = !hs_r || ((s_r > s_l) && (s_b > s_t));
    // clip box
    if (clip_x_r == '0 && clip_y_r == '0 && clip_w_r == '0 && clip_h_r == '0) begin
      c_l = '0;
      c_t = '0;
      c_r = dpw;
      c_b = dph;
    end else begin
      c_l = sv_t'(clip_x_r);
      c_t = sv_t'(clip_y_r);
      c_r = smin(sv_t'(clip_x_r) + sv_t'(clip_w_r), dpw);
      c_b = smin(sv_t'(clip_y_r) + sv_t'(clip_h_r), dph);
    end
    c_ok = (c_r > c_l) && (c_b > c_t);
    // destination box
    if (kind_r == KIND_COPY) begin
      d_wr = s_r - s_l;
      d_hb = s_b - s_t;
    end else begin
      d_wr = rw_r;
      d_hb = rh_r;
    end
    if (hd_r) begin
      d_l = smax(px_r, c_l);
      d_t = smax(py_r, c_t);
      d_r = smin(px_r + d_wr, c_r);
      d_b = smin(py_r + d_hb, c_b);
    end else begin
      d_l = c_l;
      d_t = c_t;
      d_r = c_r;
      d_b = c_b;
    end
    d_ok = !hd_r || ((d_r > d_l) && (d_b > d_t));
    cw = smin(s_r - s_l, d_r - d_l);
    ch = smin(s_b - s_t, d_b - d_t);
    if (kind_r == KIND_COPY) rect_ok = s_ok && c_ok && d_ok && cw > 0 && ch > 0;
    else rect_ok = (kind_r == KIND_FILL) && c_ok && d_ok;
  end

  // Rectangle walk counters and row base addresses
  logic [XW-1:0] i_r, wcnt_r;
  logic [YW-1:0] j_r, hcnt_r;
  logic [AW-1:0] sbase_r, dbase_r, sa_r, da_r;
  logic [AW-1:0] spitch_r, dpitch_r;
  logic          cpy_r;

  assign stat.is_rect = rect_ok;
  assign stat.last    = (i_r == wcnt_r - 1'b1) && (j_r == hcnt_r - 1'b1);

  // Result fields of the rectangle
  logic [8:0] rx_r;
  logic [7:0] ry_r;
  logic [9:0] rw_o_r;
  logic [8:0] rh_o_r;
  logic       rdrawn_r;
  logic [7:0] rpix_r;

  // Single pixel access address
  sv_t           pw, ph;
  logic          pin;
  logic [2*SW-1:0] pprod;
  assign pw  = (kind_r == KIND_WR_SRC) ? spw : dpw;
  assign ph  = (kind_r == KIND_WR_SRC) ? sph : dph;
  assign pin = (px_r >= 0) && (px_r < pw) && (py_r >= 0) && (py_r < ph);
  assign pprod = (2*SW)'(py_r) * (2*SW)'(pw) + (2*SW)'(px_r);

  // Stores
  logic [7:0] src_mem [DEPTH];
  logic [7:0] dst_mem [DEPTH];
  logic [7:0] src_q_r, dst_q_r;
  logic [AW-1:0] s_raddr, d_raddr, d_waddr, s_waddr;
  logic          s_we, d_we;
  logic [7:0]    s_wd, d_wd;
  logic          pend_cp_r;
  logic [AW-1:0] pend_da_r;
  logic          pix_rd_r;

  always_comb begin
    s_raddr = sa_r;
    d_raddr = pprod[AW-1:0];
    s_we    = cmd.pix_go && pin && (kind_r == KIND_WR_SRC);
    s_waddr = pprod[AW-1:0];
    s_wd    = color_r;
    d_we    = 1'b0;
    d_waddr = pprod[AW-1:0];
    d_wd    = color_r;
    if (cmd.pix_go && pin && kind_r == KIND_WR_DST) d_we = 1'b1;
    // fill writes directly; copy writes in the cycle after the source read
    if (cmd.step && !cpy_r) begin
      d_we    = 1'b1;
      d_waddr = da_r;
    end
    if (pend_cp_r) begin
      d_we    = 1'b1;
      d_waddr = pend_da_r;
      d_wd    = src_q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s_we) src_mem[s_waddr] <= s_wd;
    src_q_r <= src_mem[s_raddr];
  end

  always_ff @(posedge clk) begin
    if (d_we) dst_mem[d_waddr] <= d_wd;
    dst_q_r <= dst_mem[d_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) pend_cp_r <= 1'b0;
    else        pend_cp_r <= cmd.step && cpy_r;
    pend_da_r <= da_r;
  end

  // Walk: advance column, wrap to next row by adding the pitch
  always_ff @(posedge clk) begin
    if (cmd.rect_go) begin
      cpy_r    <= (kind_r == KIND_COPY);
      wcnt_r   <= XW'((kind_r == KIND_COPY) ? cw : d_r - d_l);
      hcnt_r   <= YW'((kind_r == KIND_COPY) ? ch : d_b - d_t);
      i_r      <= '0;
      j_r      <= '0;
      spitch_r <= AW'(spw);
      dpitch_r <= AW'(dpw);
      sbase_r  <= AW'(s_t) * AW'(spw) + AW'(s_l);
      sa_r     <= AW'(s_t) * AW'(spw) + AW'(s_l);
      dbase_r  <= AW'(d_t) * AW'(dpw) + AW'(d_l);
      da_r     <= AW'(d_t) * AW'(dpw) + AW'(d_l);
    end else if (cmd.step) begin
      if (i_r == wcnt_r - 1'b1) begin
        i_r     <= '0;
        j_r     <= j_r + 1'b1;
        sbase_r <= sbase_r + spitch_r;
        dbase_r <= dbase_r + dpitch_r;
        sa_r    <= sbase_r + spitch_r;
        da_r    <= dbase_r + dpitch_r;
      end else begin
        i_r  <= i_r + 1'b1;
        sa_r <= sa_r + 1'b1;
        da_r <= da_r + 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.pix_go) pix_rd_r <= pin && (kind_r == KIND_RD_DST);
    if (cmd.load) begin
      rdrawn_r <= 1'b0;
      rx_r     <= '0;
      ry_r     <= '0;
      rw_o_r   <= '0;
      rh_o_r   <= '0;
      rpix_r   <= '0;
    end else if (cmd.rect_go) begin
      rdrawn_r <= 1'b1;
      rx_r     <= 9'(d_l);
      ry_r     <= 8'(d_t);
      rw_o_r   <= 10'((kind_r == KIND_COPY) ? cw : d_r - d_l);
      rh_o_r   <= 9'((kind_r == KIND_COPY) ? ch : d_b - d_t);
    end else if (cmd.pix_go && pin && (kind_r == KIND_WR_SRC || kind_r == KIND_WR_DST)) begin
      rdrawn_r <= 1'b1;
      rx_r     <= 9'(px_r);
      ry_r     <= 8'(py_r);
      rw_o_r   <= 10'd1;
      rh_o_r   <= 9'd1;
    end else if (cmd.rd_done && pix_rd_r) begin
      rpix_r <= dst_q_r;
    end
  end

  // Output register: take the finished result, hold it while the receiver stalls
  logic [7:0] opix_r;
  logic       odrawn_r;
  logic [8:0] ox_r;
  logic [7:0] oy_r;
  logic [9:0] ow_r;
  logic [8:0] oh_r;

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      opix_r   <= rpix_r;
      odrawn_r <= rdrawn_r;
      ox_r     <= rx_r;
      oy_r     <= ry_r;
      ow_r     <= rw_o_r;
      oh_r     <= rh_o_r;
    end
  end

  assign read_pixel = opix_r;
  assign drawn      = odrawn_r;
  assign out_x      = ox_r;
  assign out_y      = oy_r;
  assign out_w      = ow_r;
  assign out_h      = oh_r;

  `include "rect_blit_fill_engine_top_assert.svh"
  `RBF_ASSERT_IMPL(a_step_busy, clk, rst_n, (cmd.step |-> !cmd.load), "step during load")
  `RBF_ASSERT_IMPL(a_no_dual_write, clk, rst_n, (pend_cp_r |-> !(cmd.step && !cpy_r)), "two dest writes")
  `RBF_ASSERT_IMPL(a_rect_nonempty, clk, rst_n, (cmd.rect_go |-> stat.is_rect), "walk of empty rect")
endmodule

// ----- hw/rtl/rect_blit_fill_engine_top.sv -----
// ----------------------------------------------------------------------------
// rect_blit_fill_engine_top
// 8-bit pixel engine: pixel access, rectangle copy and fill with clipping.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one command per transfer; tdata holds the command fields, tuser
//           the kind code. in_tready is high only while the controller is idle.
//   out_* : one result per command, held in an output register until the
//           receiver takes it.
//   cfg_* : register writes, always taken; write only while idle.
// A pixel write or read passes the states clip, pixel access, read wait
//   and output. A copy or fill passes clip, walk, write drain and output,
//   one pixel per cycle through the single write port of the destination
//   store. The next command is taken in the cycle its predecessor's result
//   is first offered.
// Reset clears the control and loads the surface registers with 320x200 and
//   an empty clip. Store contents stay undefined until written.
// A stalled receiver holds the result; the next command is still taken and
//   processed, then waits in its last step until the held result transfers.
// ----------------------------------------------------------------------------
module rect_blit_fill_engine_top #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // pos_x[10:0] pos_y[21:11] rect_w[31:22] rect_h[41:32] src_x[52:42]
  // src_y[63:53] src_w[73:64] src_h[83:74] has_src_rect[84]
  // has_dst_rect[85] pixel[93:86] zero[95:94]
  input  logic [95:0] in_tdata,
  input  logic [2:0]  in_tuser,   // kind[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  // read_pixel[7:0] drawn[8] out_x[17:9] out_y[25:18] out_w[35:26]
  // out_h[44:36] zero[47:45]
  output logic [47:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data
);
  import rbf_pkg::*;

  rbf_cmd_t  cmd;
  rbf_stat_t stat;
  logic [7:0] rp;
  logic       dr;
  logic [8:0] ox;
  logic [7:0] oy;
  logic [9:0] ow;
  logic [8:0] oh;

  assign cfg_ready = 1'b1;

  rbf_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .stat, .cmd
  );

  rbf_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
    .clk, .rst_n,
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .kind         (in_tuser),
    .pos_x        (in_tdata[10:0]),
    .pos_y        (in_tdata[21:11]),
    .rect_w       (in_tdata[31:22]),
    .rect_h       (in_tdata[41:32]),
    .src_x        (in_tdata[52:42]),
    .src_y        (in_tdata[63:53]),
    .src_w        (in_tdata[73:64]),
    .src_h        (in_tdata[83:74]),
    .has_src_rect (in_tdata[84]),
    .has_dst_rect (in_tdata[85]),
    .pixel        (in_tdata[93:86]),
    .cmd, .stat,
    .read_pixel   (rp),
    .drawn        (dr),
    .out_x        (ox),
    .out_y        (oy),
    .out_w        (ow),
    .out_h        (oh)
  );

  assign out_tdata = {3'b000, oh, ow, oy, ox, dr, rp};
endmodule
